// File: hdl/assert_macros.svh
// Assertion helpers. Each expects clk_i and rst_ni in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge, off while reset is held.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Implication variant: antecedent one cycle, consequent the next.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/crc8cr_pkg.sv
package crc8cr_pkg;

  // Message buffer depth for reverse-order mode.
  localparam int unsigned MAX_BYTES = 256;
  localparam int unsigned ADDR_W    = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
  localparam int unsigned CNT_W     = $clog2(MAX_BYTES + 1);

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_POLY       = 3'd0,
    CFG_INIT_VALUE = 3'd1,
    CFG_FINAL_XOR  = 3'd2,
    CFG_REVERSE    = 3'd3,
    CFG_REFLECT    = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last;
  } in_t;

  typedef struct packed {
    logic [7:0] crc_value;
    logic       too_long;
  } out_t;

  // Bit order swap within a byte.
  function automatic logic [7:0] mirror8(input logic [7:0] b);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) begin
      r[i] = b[7-i];
    end
    return r;
  endfunction

  // One MSB-first shift of the CRC register.
  function automatic logic [7:0] crc_bit_step(input logic [7:0] r, input logic [7:0] p);
    logic [7:0] sh;
    sh = {r[6:0], 1'b0};
    return r[7] ? (sh ^ p) : sh;
  endfunction

endpackage

// File: hdl/crc8cr_ram.sv
module crc8cr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                             clk_i,
  input  logic                             we_i,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] addr_i,
  input  logic [WIDTH-1:0]                 wdata_i,
  output logic [WIDTH-1:0]                 rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/crc8_configurable_with_reorder.sv
// CRC-8 engine, MSB first, configurable polynomial, init and final XOR.
// Input channel (in_valid_i / in_ready_o / in_data_i): one message byte per
// item, data_byte plus a last flag. Output channel (out_valid_o / out_ready_i
// / out_data_o): one item per message, crc_value and too_long.
// Configuration is a plain write port (cfg_we_i, cfg_idx_i, cfg_wdata_i); the
// user writes it only while the engine is idle; the engine does not enforce it.
// Operation: a single one-bit CRC step unit does all the work. Each byte is
// accepted and then stepped through its eight bits. In reverse mode the last
// byte is followed by a drain of the stored message, last byte first: address,
// RAM read and fold, eight steps. The result then waits in the done state and
// moves into the output register once that is free.
// Reset: all control state clears, the configuration returns to poly 0x07,
// init 0, final XOR 0, both options off. The byte buffer is not cleared; only
// bytes written in the current message are ever read back.
// Stall: a finished result waits in the output register; new bytes are still
// taken. A second result waits in the engine until the register frees up.
`include "assert_macros.svh"

module crc8_configurable_with_reorder (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic                                       in_valid_i,
  output logic                                       in_ready_o,
  input  crc8cr_pkg::in_t                            in_data_i,
  output logic                                       out_valid_o,
  input  logic                                       out_ready_i,
  output crc8cr_pkg::out_t                           out_data_o,
  input  logic                                       cfg_we_i,
  input  logic [crc8cr_pkg::CFG_IDX_W-1:0]           cfg_idx_i,
  input  logic [crc8cr_pkg::CFG_DATA_W-1:0]          cfg_wdata_i
);
  import crc8cr_pkg::*;

  localparam logic [CNT_W-1:0] MaxCnt = CNT_W'(MAX_BYTES);

  typedef enum logic [2:0] {
    S_IDLE,   // waiting for a byte
    S_FWD,    // stepping the running forward CRC
    S_RD,     // address the buffer for reverse drain
    S_LOAD,   // buffer data back, fold into register
    S_REV,    // stepping the reverse CRC
    S_DONE    // result ready for the output register
  } state_e;

  // Configuration registers
  logic [7:0] poly_q, init_q, fxor_q;
  logic       rev_q, refl_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      poly_q <= 8'h07;
      init_q <= 8'h00;
      fxor_q <= 8'h00;
      rev_q  <= 1'b0;
      refl_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_POLY:       poly_q <= cfg_wdata_i;
        CFG_INIT_VALUE: init_q <= cfg_wdata_i;
        CFG_FINAL_XOR:  fxor_q <= cfg_wdata_i;
        CFG_REVERSE:    rev_q  <= cfg_wdata_i[0];
        CFG_REFLECT:    refl_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  state_e           state_q, state_d;
  logic [7:0]       work_q, work_d;   // register under the step unit
  logic [7:0]       crc_q, crc_d;     // forward running CRC
  logic [CNT_W-1:0] cnt_q, cnt_d;     // bytes stored this message
  logic [CNT_W-1:0] idx_q, idx_d;     // reverse drain position
  logic             ovf_q, ovf_d;
  logic [2:0]       bit_q, bit_d;
  logic             last_q, last_d;
  out_t             res_q, res_d;
  out_t             out_q, out_d;
  logic             out_valid_q, out_valid_d;

  logic             in_fire;
  logic [7:0]       step_out;
  logic [7:0]       fold_src, fold_byte;
  logic [7:0]       rd_data;
  logic             ram_we;
  logic [CNT_W-1:0] idx_m1;
  logic [ADDR_W-1:0] ram_addr;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;

  // Shared datapath: one CRC bit step, one optional byte mirror
  assign step_out  = crc_bit_step(work_q, poly_q);
  assign fold_src  = (state_q == S_IDLE) ? in_data_i.data_byte : rd_data;
  assign fold_byte = refl_q ? mirror8(fold_src) : fold_src;

  // Buffer: written at the fill count on accept while not full, read during the drain
  assign idx_m1   = idx_q - CNT_W'(1);
  assign ram_we   = in_fire && (cnt_q < MaxCnt);
  assign ram_addr = (state_q == S_IDLE) ? cnt_q[ADDR_W-1:0] : idx_m1[ADDR_W-1:0];

  crc8cr_ram #(
    .WIDTH (8),
    .DEPTH (MAX_BYTES)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (in_data_i.data_byte),
    .rdata_o (rd_data)
  );

  always_comb begin
    state_d     = state_q;
    work_d      = work_q;
    crc_d       = crc_q;
    cnt_d       = cnt_q;
    idx_d       = idx_q;
    ovf_d       = ovf_q;
    bit_d       = bit_q;
    last_d      = last_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;

    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          // first byte of a message starts from the init value
          work_d = ((cnt_q == '0) ? init_q : crc_q) ^ fold_byte;
          if (cnt_q < MaxCnt) begin
            cnt_d = cnt_q + CNT_W'(1);
          end else begin
            ovf_d = 1'b1;
          end
          last_d  = in_data_i.last;
          bit_d   = 3'd0;
          state_d = S_FWD;
        end
      end
      S_FWD: begin
        work_d = step_out;
        bit_d  = bit_q + 3'd1;
        if (bit_q == 3'd7) begin
          crc_d = step_out;
          if (!last_q) begin
            state_d = S_IDLE;
          end else if (rev_q) begin
            work_d  = init_q;
            idx_d   = cnt_q;
            state_d = S_RD;
          end else begin
            res_d.crc_value = step_out ^ fxor_q;
            res_d.too_long  = 1'b0;
            state_d         = S_DONE;
          end
        end
      end
      S_RD: begin
        state_d = S_LOAD;
      end
      S_LOAD: begin
        work_d  = work_q ^ fold_byte;
        idx_d   = idx_m1;
        bit_d   = 3'd0;
        state_d = S_REV;
      end
      S_REV: begin
        work_d = step_out;
        bit_d  = bit_q + 3'd1;
        if (bit_q == 3'd7) begin
          if (idx_q == '0) begin
            res_d.crc_value = step_out ^ fxor_q;
            res_d.too_long  = ovf_q;
            state_d         = S_DONE;
          end else begin
            state_d = S_RD;
          end
        end
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          cnt_d       = '0;
          ovf_d       = 1'b0;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      work_q      <= '0;
      crc_q       <= '0;
      cnt_q       <= '0;
      idx_q       <= '0;
      ovf_q       <= 1'b0;
      bit_q       <= '0;
      last_q      <= 1'b0;
      res_q       <= '0;
      out_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      work_q      <= work_d;
      crc_q       <= crc_d;
      cnt_q       <= cnt_d;
      idx_q       <= idx_d;
      ovf_q       <= ovf_d;
      bit_q       <= bit_d;
      last_q      <= last_d;
      res_q       <= res_d;
      out_q       <= out_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Assertions
  `ASSERT_CLK(a_ovf_full, !ovf_q || (cnt_q == MaxCnt), "overflow flag set with buffer not full")
  `ASSERT_CLK(a_cnt_range, cnt_q <= MaxCnt, "byte count beyond buffer depth")
  `ASSERT_NEXT(a_accept_fwd, in_fire, state_q == S_FWD, "accepted item did not start stepping")
  `ASSERT_CLK(a_out_src, !$rose(out_valid_q) || $past(state_q == S_DONE), "result without done")

endmodule

// File: tb/crc8_result_checker.sv
module crc8_result_checker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [crc8cr_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [crc8cr_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                              in_valid_i,
  input  logic                              in_ready_i,
  input  crc8cr_pkg::in_t                   in_item_i,
  input  logic                              out_valid_i,
  input  logic                              out_ready_i,
  input  crc8cr_pkg::out_t                  out_item_i,
  output int                                fail_count_o,
  output int                                pending_o
);
  import crc8cr_pkg::*;

  // Shadow of the configuration registers.
  logic [7:0]  poly_q;
  logic [7:0]  init_q;
  logic [7:0]  xor_q;
  logic        reverse_q;
  logic        reflect_q;

  // Current message as the engine sees it.
  logic [7:0]  msg_store [MAX_BYTES];
  int unsigned msg_len;
  logic        msg_dropped;
  logic [7:0]  run_crc;

  out_t        crc_expected_q [$];
  int          mismatches;

  function automatic logic [7:0] flip_byte(input logic [7:0] b);
    logic [7:0] r;
    r = '0;
    for (int i = 0; i < 8; i++) begin
      r = {r[6:0], b[i]};
    end
    return r;
  endfunction

  // Fold one byte into the register, MSB first.
  function automatic logic [7:0] crc8_absorb(input logic [7:0] acc, input logic [7:0] b,
                                             input logic [7:0] gen);
    logic [7:0] r;
    r = acc ^ b;
    repeat (8) begin
      r = r[7] ? ({r[6:0], 1'b0} ^ gen) : {r[6:0], 1'b0};
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : track
    logic [7:0] byte_in;
    logic [7:0] acc;
    out_t       want;
    out_t       got;
    if (!rst_ni) begin
      poly_q      = 8'h07;
      init_q      = 8'h00;
      xor_q       = 8'h00;
      reverse_q   = 1'b0;
      reflect_q   = 1'b0;
      msg_len     = 0;
      msg_dropped = 1'b0;
      run_crc     = 8'h00;
      mismatches  = 0;
      crc_expected_q.delete();
      pending_o    <= 0;
      fail_count_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_POLY:       poly_q    = cfg_wdata_i;
          CFG_INIT_VALUE: init_q    = cfg_wdata_i;
          CFG_FINAL_XOR:  xor_q     = cfg_wdata_i;
          CFG_REVERSE:    reverse_q = cfg_wdata_i[0];
          CFG_REFLECT:    reflect_q = cfg_wdata_i[0];
          default: ;
        endcase
      end

      if (out_valid_i && out_ready_i) begin
        got = out_item_i;
        if (crc_expected_q.size() == 0) begin
          $error("unexpected item: crc_value %02h too_long %0b", got.crc_value, got.too_long);
          mismatches++;
        end else begin
          want = crc_expected_q.pop_front();
          if (got.crc_value !== want.crc_value) begin
            $error("crc_value: expected %02h, actual %02h", want.crc_value, got.crc_value);
            mismatches++;
          end
          if (got.too_long !== want.too_long) begin
            $error("too_long: expected %0b, actual %0b", want.too_long, got.too_long);
            mismatches++;
          end
        end
      end

      if (in_valid_i && in_ready_i) begin
        byte_in = in_item_i.data_byte;
        if (msg_len == 0) run_crc = init_q;
        if (msg_len < MAX_BYTES) begin
          msg_store[msg_len] = byte_in;
          msg_len++;
        end else begin
          msg_dropped = 1'b1;
        end
        run_crc = crc8_absorb(run_crc, reflect_q ? flip_byte(byte_in) : byte_in, poly_q);
        if (in_item_i.last) begin
          if (reverse_q) begin
            acc = init_q;
            for (int k = int'(msg_len) - 1; k >= 0; k--) begin
              acc = crc8_absorb(acc, reflect_q ? flip_byte(msg_store[k]) : msg_store[k], poly_q);
            end
            want.crc_value = acc ^ xor_q;
            want.too_long  = msg_dropped;
          end else begin
            want.crc_value = run_crc ^ xor_q;
            want.too_long  = 1'b0;
          end
          crc_expected_q.push_back(want);
          run_crc     = init_q;
          msg_len     = 0;
          msg_dropped = 1'b0;
        end
      end

      pending_o    <= crc_expected_q.size();
      fail_count_o <= mismatches;
    end
  end

endmodule

// File: tb/testbench.sv
module testbench;
  import crc8cr_pkg::*;

  localparam int GAP_MAX       = 14;
  localparam int SETTLE_CYCLES = 40;   // covers one byte still in flight, with margin
  localparam int HOLD_CYCLES   = 400;
  localparam int RANDOM_ITEMS  = 800;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_ready_o;
  in_t                   in_data_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  out_t                  out_data_o;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  int   fail_count;
  int   crc_pending;     // results still owed by the engine, a registered copy of the checker's count
  int   items_sent;
  int   rx_gap;
  logic quiet;           // neither side draws random gaps while set
  logic hold_req;        // one-cycle pulse asking the result sink for a long hold-off

  crc8_configurable_with_reorder dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  crc8_result_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .in_item_i    (in_data_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_item_i   (out_data_o),
    .fail_count_o (fail_count),
    .pending_o    (crc_pending)
  );

  initial begin : clock_gen
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Hard stop in case the engine hangs.
  initial begin : watchdog
    #1000000;
    $display("Regression FAIL");
    $finish;
  end

  // Result sink: after every accepted item it draws a stall; a hold request
  // replaces that with one long stretch of ready low.
  initial begin : result_sink
    rx_gap      = 0;
    out_ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        rx_gap = HOLD_CYCLES;
      end else if (out_valid_o && out_ready_i) begin
        rx_gap = quiet ? 0 : $urandom_range(0, GAP_MAX);
      end else if (rx_gap > 0) begin
        rx_gap--;
      end
      out_ready_i <= (rx_gap == 0);
    end
  end

  // Offer one byte after a random gap. Valid is left high on return so that a
  // zero-gap follow-up keeps it high; every pause lowers it first.
  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, GAP_MAX);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= {b, last};
    do @(posedge clk_i); while (!in_ready_o);
    items_sent++;
  endtask

  task automatic send_message(input int len);
    for (int k = 0; k < len; k++) begin
      send_byte(8'($urandom_range(0, 255)), k == len - 1);
    end
  endtask

  // Sender stops and waits until every CRC owed has come out, then gives a
  // byte still in the engine (no result of its own) time to finish.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (crc_pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Back-to-back writes of all five registers; only legal while idle.
  task automatic apply_settings(input logic [7:0] poly, input logic [7:0] init,
                                input logic [7:0] fxor, input logic rev, input logic refl);
    cfg_idx_e   reg_sel [5];
    logic [7:0] reg_val [5];
    reg_sel = '{CFG_POLY, CFG_INIT_VALUE, CFG_FINAL_XOR, CFG_REVERSE, CFG_REFLECT};
    reg_val = '{poly, init, fxor, {7'd0, rev}, {7'd0, refl}};
    for (int k = 0; k < 5; k++) begin
      cfg_we_i    <= 1'b1;
      cfg_idx_i   <= reg_sel[k];
      cfg_wdata_i <= reg_val[k];
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
  endtask

  // Register values lean on the extremes.
  function automatic logic [7:0] pick_reg_value();
    case ($urandom_range(0, 3))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Mostly very short messages, some medium ones.
  function automatic int pick_len();
    if ($urandom_range(0, 99) < 70) return $urandom_range(1, 4);
    return $urandom_range(5, 24);
  endfunction

  initial begin : stimulus
    int         phase;
    int         budget;
    int         mark;
    logic [7:0] poly_v;
    logic [7:0] init_v;
    logic [7:0] xor_v;
    logic       rev_v;
    logic       refl_v;

    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = CFG_POLY;
    cfg_wdata_i = '0;
    quiet       = 1'b0;
    hold_req    = 1'b0;
    items_sent  = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // --- Directed part ---
    // Reset settings: poly 07, init 0, no final xor, forward, no reflect.
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h80, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'h5A, 1'b1);
    wait_drained();
    // All registers at their top values: reverse and reflect on.
    apply_settings(8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hA5, 1'b1);
    send_byte(8'h01, 1'b1);
    wait_drained();
    // Zero polynomial, reflect only.
    apply_settings(8'h00, 8'h00, 8'h00, 1'b0, 1'b1);
    send_byte(8'h12, 1'b0);
    send_byte(8'h34, 1'b0);
    send_byte(8'h56, 1'b1);
    wait_drained();
    // Reverse only.
    apply_settings(8'h31, 8'hFF, 8'h00, 1'b1, 1'b0);
    send_byte(8'hFE, 1'b0);
    send_byte(8'h7F, 1'b1);
    wait_drained();
    // Options flipped inside a message: the forward register keeps what it
    // absorbed, the reverse pass uses the settings present at the last byte.
    apply_settings(8'h07, 8'h00, 8'h00, 1'b0, 1'b0);
    send_byte(8'hC3, 1'b0);
    send_byte(8'h3C, 1'b0);
    wait_drained();
    apply_settings(8'h07, 8'h00, 8'h00, 1'b1, 1'b1);
    send_byte(8'h81, 1'b1);
    send_byte(8'h55, 1'b0);
    wait_drained();
    apply_settings(8'h1D, 8'hA5, 8'h5A, 1'b0, 1'b0);
    send_byte(8'hAA, 1'b1);

    // --- Random part, in phases of fixed settings ---
    items_sent = 0;
    for (phase = 0; items_sent < RANDOM_ITEMS; phase++) begin
      wait_drained();
      quiet  = ($urandom_range(0, 4) == 0);
      poly_v = pick_reg_value();
      init_v = pick_reg_value();
      xor_v  = pick_reg_value();
      rev_v  = 1'($urandom_range(0, 1));
      refl_v = 1'($urandom_range(0, 1));
      if (phase == 3) rev_v = 1'b1;
      apply_settings(poly_v, init_v, xor_v, rev_v, refl_v);
      mark = items_sent;
      case (phase)
        1: begin
          // Receiver deaf for a long stretch while bytes keep coming: the
          // output register and the engine fill up and the input stalls.
          quiet = 1'b1;
          hold_req <= 1'b1;
          @(posedge clk_i);
          hold_req <= 1'b0;
          repeat (30) send_message($urandom_range(1, 2));
        end
        3: begin
          // Overflow in reverse mode: extra bytes dropped, too_long set.
          send_message(MAX_BYTES + $urandom_range(1, 3));
        end
        7: begin
          // Exactly full store, no overflow.
          send_message(MAX_BYTES);
        end
        default: begin
          budget = $urandom_range(20, 60);
          while (items_sent - mark < budget) send_message(pick_len());
          // Sometimes leave a message open across the settings change.
          if ($urandom_range(0, 2) == 0) begin
            repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)), 1'b0);
          end
        end
      endcase
    end
    // Close any message still open.
    send_byte(8'($urandom_range(0, 255)), 1'b1);

    wait_drained();
    if (fail_count == 0 && crc_pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
